/* hdl/mgab_pkg.sv */
// ----------------------------------------------------------------------------
// mgab_pkg
// Shared widths, configuration and pipeline types for the text box compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package mgab_pkg;

    // Character cell geometry
    localparam int CELL_WIDTH  = 8;
    localparam int CELL_HEIGHT = 16;

    // Field widths
    localparam int COORD_W  = 12;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int MARGIN_W = 12;
    localparam int PIX_W    = 32;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;

    // Box edges one past the last pixel
    localparam int RIGHT_W  = $clog2((1 << COORD_W) + CELL_WIDTH * (1 << COL_W));
    localparam int BOTTOM_W = $clog2((1 << COORD_W) + CELL_HEIGHT * (1 << ROW_W));

    // Corner distance: floor square root of a sum of two squares
    localparam int SQ_W        = 2 * COORD_W;
    localparam int RAD_W       = 2 * COORD_W + 4;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int SREM_W      = ROOT_W + 2;
    localparam int DIST_W      = COORD_W + 1;
    localparam int ROOT_STEPS  = 2;
    localparam int ROOT_STAGES = RAD_W / (2 * ROOT_STEPS);
    localparam int DIV_STAGES  = CH_W / ROOT_STEPS;

    // Blend products
    localparam int PROD_W = 2 * CH_W + 1;

    // Pipeline depth
    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 4;
    localparam int PIPE_STAGES  = FRONT_STAGES + ROOT_STAGES + BACK_STAGES;

    // Port widths
    localparam int IN_W       = 2 * COORD_W + 2 * PIX_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BOX_LEFT        = 3'd0,
        REG_BOX_TOP         = 3'd1,
        REG_BOX_COLUMNS     = 3'd2,
        REG_BOX_ROWS        = 3'd3,
        REG_GRADIENT_MARGIN = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0]  left;
        logic [COORD_W-1:0]  top;
        logic [COL_W-1:0]    cols;
        logic [ROW_W-1:0]    rows;
        logic [MARGIN_W-1:0] margin;
    } mgab_cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0]    colour;
        logic [PIX_W-1:0]    bg;
        logic                x_in;
        logic                y_in;
        logic [COORD_W-1:0]  dx;
        logic [COORD_W-1:0]  dy;
        logic [RAD_W-1:0]    rad;
        logic [SREM_W-1:0]   srem;
        logic [ROOT_W-1:0]   root;
        logic [CH_W-1:0]     dnum;
        logic [MARGIN_W-1:0] drem;
        logic [CH_W-1:0]     quot;
    } mgab_root_item_t;

    typedef enum logic [1:0] {
        KIND_BOX   = 2'd0,
        KIND_BACK  = 2'd1,
        KIND_BLEND = 2'd2
    } pix_kind_t;

endpackage

`default_nettype wire

/* hdl/mgab_front.sv */
// ----------------------------------------------------------------------------
// mgab_front
// Box edges, in-box tests, edge offsets, their squares and the root/divide
// seed. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mgab_front (
    input  wire logic                                     aclk,
    input  wire logic [mgab_pkg::FRONT_STAGES-1:0]        stage_en,
    input  wire mgab_pkg::mgab_cfg_t                      cfg,
    input  wire logic [mgab_pkg::IN_W-1:0]                in_data,
    output mgab_pkg::mgab_root_item_t                     item_out
);
    import mgab_pkg::*;

    // Stage 0: edges
    logic [COORD_W-1:0]  s0_x_reg, s0_y_reg;
    logic [PIX_W-1:0]    s0_colour_reg, s0_bg_reg;
    logic [RIGHT_W-1:0]  s0_right_reg, s0_right_next;
    logic [BOTTOM_W-1:0] s0_bottom_reg, s0_bottom_next;

    // Stage 1: tests and offsets
    logic                s1_x_in_reg, s1_y_in_reg, s1_x_in_next, s1_y_in_next;
    logic [COORD_W-1:0]  s1_dx_reg, s1_dy_reg, s1_dx_next, s1_dy_next;
    logic [PIX_W-1:0]    s1_colour_reg, s1_bg_reg;

    // Stage 2: squares
    logic                s2_x_in_reg, s2_y_in_reg;
    logic [COORD_W-1:0]  s2_dx_reg, s2_dy_reg;
    logic [SQ_W-1:0]     s2_dxsq_reg, s2_dysq_reg;
    logic [PIX_W-1:0]    s2_colour_reg, s2_bg_reg;

    // Stage 3: seed
    mgab_root_item_t     s3_item_reg, s3_item_next;

    logic [RIGHT_W-1:0]  x_ext;
    logic [BOTTOM_W-1:0] y_ext;

    assign s0_right_next  = RIGHT_W'(cfg.left) + RIGHT_W'(cfg.cols) * RIGHT_W'(CELL_WIDTH);
    assign s0_bottom_next = BOTTOM_W'(cfg.top) + BOTTOM_W'(cfg.rows) * BOTTOM_W'(CELL_HEIGHT);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s0_x_reg      <= in_data[COORD_W-1:0];
            s0_y_reg      <= in_data[2*COORD_W-1:COORD_W];
            s0_colour_reg <= in_data[2*COORD_W+PIX_W-1:2*COORD_W];
            s0_bg_reg     <= in_data[IN_W-1:2*COORD_W+PIX_W];
            s0_right_reg  <= s0_right_next;
            s0_bottom_reg <= s0_bottom_next;
        end
    end

    assign x_ext = RIGHT_W'(s0_x_reg);
    assign y_ext = BOTTOM_W'(s0_y_reg);

    always_comb begin
        s1_x_in_next = (s0_x_reg >= cfg.left) && (x_ext < s0_right_reg);
        s1_y_in_next = (s0_y_reg >= cfg.top) && (y_ext < s0_bottom_reg);
        // Pixels right of or below the box count from the first pixel past it
        priority if (s0_x_reg < cfg.left) begin
            s1_dx_next = cfg.left - s0_x_reg;
        end else if (x_ext >= s0_right_reg) begin
            s1_dx_next = COORD_W'(x_ext - s0_right_reg);
        end else begin
            s1_dx_next = '0;
        end
        priority if (s0_y_reg < cfg.top) begin
            s1_dy_next = cfg.top - s0_y_reg;
        end else if (y_ext >= s0_bottom_reg) begin
            s1_dy_next = COORD_W'(y_ext - s0_bottom_reg);
        end else begin
            s1_dy_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_x_in_reg   <= s1_x_in_next;
            s1_y_in_reg   <= s1_y_in_next;
            s1_dx_reg     <= s1_dx_next;
            s1_dy_reg     <= s1_dy_next;
            s1_colour_reg <= s0_colour_reg;
            s1_bg_reg     <= s0_bg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s2_x_in_reg   <= s1_x_in_reg;
            s2_y_in_reg   <= s1_y_in_reg;
            s2_dx_reg     <= s1_dx_reg;
            s2_dy_reg     <= s1_dy_reg;
            s2_dxsq_reg   <= SQ_W'(s1_dx_reg) * SQ_W'(s1_dx_reg);
            s2_dysq_reg   <= SQ_W'(s1_dy_reg) * SQ_W'(s1_dy_reg);
            s2_colour_reg <= s1_colour_reg;
            s2_bg_reg     <= s1_bg_reg;
        end
    end

    always_comb begin
        s3_item_next.colour = s2_colour_reg;
        s3_item_next.bg     = s2_bg_reg;
        s3_item_next.x_in   = s2_x_in_reg;
        s3_item_next.y_in   = s2_y_in_reg;
        s3_item_next.dx     = s2_dx_reg;
        s3_item_next.dy     = s2_dy_reg;
        s3_item_next.rad    = RAD_W'(s2_dxsq_reg) + RAD_W'(s2_dysq_reg);
        s3_item_next.srem   = '0;
        s3_item_next.root   = '0;
        // 255 - alpha
        s3_item_next.dnum   = ~s2_colour_reg[PIX_W-1 -: CH_W];
        s3_item_next.drem   = '0;
        s3_item_next.quot   = '0;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s3_item_reg <= s3_item_next;
        end
    end

    assign item_out = s3_item_reg;

endmodule

`default_nettype wire

/* hdl/mgab_root_stage.sv */
// ----------------------------------------------------------------------------
// mgab_root_stage
// Two digits of the integer square root, and optionally two quotient bits
// of the gradient step division, per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mgab_root_stage (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic                              div_on,
    input  wire logic [mgab_pkg::MARGIN_W-1:0]     margin,
    input  wire mgab_pkg::mgab_root_item_t         item_in,
    output mgab_pkg::mgab_root_item_t              item_out
);
    import mgab_pkg::*;

    mgab_root_item_t item_reg, item_next;

    always_comb begin : step_logic
        logic [SREM_W-1:0]   shifted;
        logic [SREM_W-1:0]   trial;
        logic [MARGIN_W:0]   dshift;
        item_next = item_in;
        for (int i = 0; i < ROOT_STEPS; i++) begin
            // Root digit: bring down two radicand bits, try 4*root + 1
            shifted = {item_next.srem[SREM_W-3:0], item_next.rad[RAD_W-1 -: 2]};
            item_next.rad = {item_next.rad[RAD_W-3:0], 2'b00};
            trial = {item_next.root, 2'b01};
            if (shifted >= trial) begin
                item_next.srem = shifted - trial;
                item_next.root = {item_next.root[ROOT_W-2:0], 1'b1};
            end else begin
                item_next.srem = shifted;
                item_next.root = {item_next.root[ROOT_W-2:0], 1'b0};
            end
            // Quotient bit: restoring division by the margin
            if (div_on) begin
                dshift = {item_next.drem, item_next.dnum[CH_W-1]};
                item_next.dnum = {item_next.dnum[CH_W-2:0], 1'b0};
                if (dshift >= {1'b0, margin}) begin
                    item_next.drem = MARGIN_W'(dshift - {1'b0, margin});
                    item_next.quot = {item_next.quot[CH_W-2:0], 1'b1};
                end else begin
                    item_next.drem = dshift[MARGIN_W-1:0];
                    item_next.quot = {item_next.quot[CH_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

`default_nettype wire

/* hdl/mgab_back.sv */
// ----------------------------------------------------------------------------
// mgab_back
// Distance pick, gradient alpha, per-channel blend and the output register.
// Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mgab_back (
    input  wire logic                                  aclk,
    input  wire logic [mgab_pkg::BACK_STAGES-1:0]      stage_en,
    input  wire logic [mgab_pkg::MARGIN_W-1:0]         margin,
    input  wire mgab_pkg::mgab_root_item_t             item_in,
    output logic [mgab_pkg::PIX_W-1:0]                 pixel_out
);
    import mgab_pkg::*;

    // Stage 0: distance, kind, step * distance (low byte)
    logic [DIST_W-1:0]        box_dist;
    logic [CH_W+DIST_W-1:0]   prod_full;
    pix_kind_t                s0_kind_reg, s0_kind_next;
    logic [CH_W-1:0]          s0_prod_reg;
    logic [PIX_W-1:0]         s0_colour_reg, s0_bg_reg;

    // Stage 1: weights
    logic [CH_W-1:0]          ramped_alpha;
    pix_kind_t                s1_kind_reg;
    logic [CH_W-1:0]          s1_wf_reg;
    logic [CH_W:0]            s1_wb_reg;
    logic [PIX_W-1:0]         s1_colour_reg, s1_bg_reg;

    // Stage 2: channel products
    pix_kind_t                s2_kind_reg;
    logic [2*CH_W-1:0]        s2_pf_reg [NUM_CH];
    logic [PROD_W-1:0]        s2_pb_reg [NUM_CH];
    logic [PIX_W-1:0]         s2_colour_reg, s2_bg_reg;

    // Stage 3: output
    logic [PIX_W-1:0]         blend_pix;
    logic [PROD_W-1:0]        ch_sum [NUM_CH];
    logic [PIX_W-1:0]         s3_pixel_reg, s3_pixel_next;

    always_comb begin
        priority if (item_in.x_in) begin
            box_dist = DIST_W'(item_in.dy);
        end else if (item_in.y_in) begin
            box_dist = DIST_W'(item_in.dx);
        end else begin
            box_dist = item_in.root[DIST_W-1:0];
        end
        priority if (item_in.x_in && item_in.y_in) begin
            s0_kind_next = KIND_BOX;
        end else if (margin == '0 || box_dist > DIST_W'(margin)) begin
            s0_kind_next = KIND_BACK;
        end else begin
            s0_kind_next = KIND_BLEND;
        end
    end

    // The ramped alpha wraps to a byte, so only the product's low byte matters
    assign prod_full = (CH_W+DIST_W)'(item_in.quot) * (CH_W+DIST_W)'(box_dist);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s0_kind_reg   <= s0_kind_next;
            s0_prod_reg   <= prod_full[CH_W-1:0];
            s0_colour_reg <= item_in.colour;
            s0_bg_reg     <= item_in.bg;
        end
    end

    assign ramped_alpha = s0_colour_reg[PIX_W-1 -: CH_W] + s0_prod_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_kind_reg   <= s0_kind_reg;
            s1_wf_reg     <= ~ramped_alpha;
            s1_wb_reg     <= {1'b0, ramped_alpha} + (CH_W+1)'(1);
            s1_colour_reg <= s0_colour_reg;
            s1_bg_reg     <= s0_bg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s2_kind_reg   <= s1_kind_reg;
            s2_colour_reg <= s1_colour_reg;
            s2_bg_reg     <= s1_bg_reg;
            for (int c = 0; c < NUM_CH; c++) begin
                s2_pf_reg[c] <= (2*CH_W)'(s1_wf_reg) * (2*CH_W)'(s1_colour_reg[c*CH_W +: CH_W]);
                s2_pb_reg[c] <= PROD_W'(s1_wb_reg) * PROD_W'(s1_bg_reg[c*CH_W +: CH_W]);
            end
        end
    end

    always_comb begin
        blend_pix = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            ch_sum[c] = PROD_W'(s2_pf_reg[c]) + s2_pb_reg[c];
            blend_pix[c*CH_W +: CH_W] = ch_sum[c][2*CH_W-1:CH_W];
        end
        unique case (s2_kind_reg)
            KIND_BOX:   s3_pixel_next = s2_colour_reg;
            KIND_BACK:  s3_pixel_next = s2_bg_reg;
            KIND_BLEND: s3_pixel_next = blend_pix;
            default:    s3_pixel_next = s2_bg_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s3_pixel_reg <= s3_pixel_next;
        end
    end

    assign pixel_out = s3_pixel_reg;

endmodule

`default_nettype wire

/* hdl/margin_gradient_alpha_blend.sv */
// Depth: 15 register stages from s_ to m_. Throughput: one pixel per clock unless
// m_ stalls a full pipe; the square root and the step division are
// fully pipelined at two digits per stage, so nothing in the path iterates.
// Backpressure: a stage advances when it or a later stage is empty or m_ moves;
// bubbles collapse, so input keeps flowing under a stall until the pipe is full.
// Reset: aresetn (sync, active low) clears all valid bits and the config registers.
// ----------------------------------------------------------------------------
// margin_gradient_alpha_blend
// Per-pixel compositor for a text box over a background image: box colour
// inside, alpha-ramped blend within the margin, background beyond it.
// ----------------------------------------------------------------------------
`default_nettype none

module margin_gradient_alpha_blend (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Pixel input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [11:0] pixel_x, [23:12] pixel_y, [55:24] box_colour,
    // [87:56] background_pixel
    input  wire logic [mgab_pkg::IN_W-1:0]          s_tdata,
    // Composited output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [31:0] out_pixel
    output logic [mgab_pkg::PIX_W-1:0]              m_tdata,
    // Configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mgab_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [mgab_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import mgab_pkg::*;

    mgab_cfg_t               cfg_reg;
    logic [PIPE_STAGES-1:0]  valid_reg, valid_next;
    logic [PIPE_STAGES-1:0]  stage_en;
    mgab_root_item_t         root_item [ROOT_STAGES+1];

    // ------------------------------------------------------------------
    // Configuration registers: always ready, a write shows in cfg_reg in the cycle after it is taken.
    // Unknown indexes are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_BOX_LEFT:        cfg_reg.left   <= cfg_wdata[COORD_W-1:0];
                REG_BOX_TOP:         cfg_reg.top    <= cfg_wdata[COORD_W-1:0];
                REG_BOX_COLUMNS:     cfg_reg.cols   <= cfg_wdata[COL_W-1:0];
                REG_BOX_ROWS:        cfg_reg.rows   <= cfg_wdata[ROW_W-1:0];
                REG_GRADIENT_MARGIN: cfg_reg.margin <= cfg_wdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Stage k advances when some stage from k to
    // the output holds a bubble, or the output beat is being taken.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_en
        assign stage_en[k] = m_tready || !(&valid_reg[PIPE_STAGES-1:k]);
    end

    // Shift valid bits forward in the stages that advance, hold the rest
    assign valid_next = ({valid_reg[PIPE_STAGES-2:0], s_tvalid} & stage_en)
                      | (valid_reg & ~stage_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];

    // ------------------------------------------------------------------
    // Datapath: front (edges, offsets, squares), seven root/divide stages,
    // back (distance pick, alpha ramp, blend, output register).
    // ------------------------------------------------------------------
    mgab_front u_front (
        .aclk     (aclk),
        .stage_en (stage_en[FRONT_STAGES-1:0]),
        .cfg      (cfg_reg),
        .in_data  (s_tdata),
        .item_out (root_item[0])
    );

    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
        mgab_root_stage u_root (
            .aclk     (aclk),
            .en       (stage_en[FRONT_STAGES+k]),
            .div_on   ((k < DIV_STAGES) ? 1'b1 : 1'b0),
            .margin   (cfg_reg.margin),
            .item_in  (root_item[k]),
            .item_out (root_item[k+1])
        );
    end

    mgab_back u_back (
        .aclk      (aclk),
        .stage_en  (stage_en[PIPE_STAGES-1 -: BACK_STAGES]),
        .margin    (cfg_reg.margin),
        .item_in   (root_item[ROOT_STAGES]),
        .pixel_out (m_tdata)
    );

    // ------------------------------------------------------------------
    // Checks on the flow control
    // ------------------------------------------------------------------
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted beat did not enter the first stage");

    a_stall_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_reg & ~stage_en) != '0) |=>
            (($past(valid_reg & ~stage_en) & ~valid_reg) == '0))
        else $error("stalled stage lost its beat");

    a_empty_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg == '0) |=> !m_tvalid)
        else $error("output beat from an empty pipeline");

endmodule

`default_nettype wire

/* dv/margin_gradient_alpha_blend_tb.sv */
// ----------------------------------------------------------------------------
// margin_gradient_alpha_blend_tb
// Self-checking bench for the text box compositor. A directed table covers
// the reset state, box edges, corners, margin limits and masked register
// writes. Randomized phases follow, each with its own box and margin. Every
// accepted pixel is scored in order against a table value or the in-bench compositor model.
// ----------------------------------------------------------------------------
`default_nettype none

module margin_gradient_alpha_blend_tb;
    import mgab_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_PIXELS   = 128;

    // Indexes past the register list; writes there must leave the box alone
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef enum bit {
        ROW_CFG,
        ROW_PIX
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] idx;
        logic [CFG_DATA_W-1:0] val;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [PIX_W-1:0]      colour;
        logic [PIX_W-1:0]      bg;
        bit                    has_want;
        logic [PIX_W-1:0]      want;
    } directed_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    mgab_cfg_t        model_cfg = '0;
    logic [PIX_W-1:0] expected_pixels[$];
    logic [PIX_W-1:0] want_pixel;
    directed_row_t    directed_rows[$];
    int unsigned      pixel_errors = 0;
    int unsigned      idle_cycles  = 0;
    bit               sender_calm  = 1'b0;
    int               stall_left   = 0;
    int               calm_left    = 0;
    bit               recv_calm    = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    margin_gradient_alpha_blend dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Compositor model
    // ------------------------------------------------------------------------

    function automatic int unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return 32'(root);
    endfunction

    function automatic logic [PIX_W-1:0] composite_pixel(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [PIX_W-1:0]   colour,
        input logic [PIX_W-1:0]   bg
    );
        int unsigned      left, top, right, bottom, margin;
        int unsigned      dx, dy, box_dist, alpha, ramp, wf, wb, chan;
        int               k;
        bit               x_in, y_in;
        logic [PIX_W-1:0] blended;
        left   = model_cfg.left;
        top    = model_cfg.top;
        margin = model_cfg.margin;
        right  = left + CELL_WIDTH * 32'(model_cfg.cols);
        bottom = top + CELL_HEIGHT * 32'(model_cfg.rows);
        x_in   = (x >= left) && (x < right);
        y_in   = (y >= top) && (y < bottom);
        if (x_in && y_in) return colour;
        if (margin == 0) return bg;
        // right and bottom offsets count from the first pixel past the box
        dx = (x < left) ? left - x : ((x >= right) ? x - right : 0);
        dy = (y < top) ? top - y : ((y >= bottom) ? y - bottom : 0);
        if (x_in)
            box_dist = dy;
        else if (y_in)
            box_dist = dx;
        else
            box_dist = floor_root(longint'(dx) * dx + longint'(dy) * dy);
        if (box_dist > margin) return bg;
        alpha = colour[31:24];
        ramp  = (255 - alpha) / margin;
        alpha = (alpha + ramp * box_dist) & 32'hff;
        wf    = 255 - alpha;
        wb    = alpha + 1;
        blended = '0;
        for (k = 0; k < NUM_CH; k++) begin
            chan = (wf * colour[8*k +: 8] + wb * bg[8*k +: 8]) / 256;
            blended[8*k +: 8] = chan[7:0];
        end
        return blended;
    endfunction

    function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_BOX_LEFT:        model_cfg.left   = val;
            REG_BOX_TOP:         model_cfg.top    = val;
            REG_BOX_COLUMNS:     model_cfg.cols   = val[COL_W-1:0];
            REG_BOX_ROWS:        model_cfg.rows   = val[ROW_W-1:0];
            REG_GRADIENT_MARGIN: model_cfg.margin = val;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Idle and stall lengths: mostly short, now and then long
    // ------------------------------------------------------------------------

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: random stalls, with calm stretches where no new stall starts
    always @(negedge aclk) begin
        if (calm_left == 0) begin
            recv_calm = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(50, 300);
        end else begin
            calm_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!recv_calm && $urandom_range(0, 4) == 0) stall_left = stall_length();
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard and watchdog
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected out_pixel beat, got %08h", $time, m_tdata);
                pixel_errors++;
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (m_tdata !== want_pixel) begin
                    $display("%0t: out_pixel mismatch, expected %08h, got %08h",
                             $time, want_pixel, m_tdata);
                    pixel_errors++;
                end
            end
        end
    end

    // Any beat on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d pixels outstanding",
                     $time, expected_pixels.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Drive one pixel beat; the expectation is formed when the beat is taken
    task automatic send_pixel(input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y,
                              input logic [PIX_W-1:0]   colour,
                              input logic [PIX_W-1:0]   bg,
                              input bit                 has_want,
                              input logic [PIX_W-1:0]   want);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {bg, colour, y, x};
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(has_want ? want : composite_pixel(x, y, colour, bg));
        gap = sender_calm ? 0 : sender_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic hold_sender();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic hold_cfg();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------

    function automatic void add_reg(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        directed_row_t row;
        row.kind     = ROW_CFG;
        row.idx      = idx;
        row.val      = val;
        row.has_want = 1'b0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pix(input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y,
                                    input logic [PIX_W-1:0]   colour,
                                    input logic [PIX_W-1:0]   bg,
                                    input bit                 has_want,
                                    input logic [PIX_W-1:0]   want);
        directed_row_t row;
        row.kind     = ROW_PIX;
        row.x        = x;
        row.y        = y;
        row.colour   = colour;
        row.bg       = bg;
        row.has_want = has_want;
        row.want     = want;
        directed_rows.push_back(row);
    endfunction

    task automatic build_directed();
        // Reset state: empty box at the origin and no margin, so background wins
        add_pix(12'd0,    12'd0,    32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000);
        add_pix(12'd4095, 12'd4095, 32'hffff_ffff, 32'hffff_ffff, 1, 32'hffff_ffff);
        add_pix(12'h555,  12'haaa,  32'h1234_5678, 32'h9abc_def0, 1, 32'h9abc_def0);
        // Box of 4x2 cells at (100,50): x 100..131, y 50..81, margin 20
        add_reg(REG_BOX_LEFT,        12'd100);
        add_reg(REG_BOX_TOP,         12'd50);
        add_reg(REG_BOX_COLUMNS,     12'd4);
        add_reg(REG_BOX_ROWS,        12'd2);
        add_reg(REG_GRADIENT_MARGIN, 12'd20);
        add_pix(12'd100, 12'd50, 32'h80aa_bbcc, 32'h1122_3344, 1, 32'h80aa_bbcc);
        add_pix(12'd131, 12'd81, 32'h00ff_ffff, 32'h0000_0000, 1, 32'h00ff_ffff);
        add_pix(12'd132, 12'd60, 32'h40ff_8000, 32'h0000_ff80, 0, '0); // first pixel right
        add_pix(12'd99,  12'd60, 32'h40ff_8000, 32'h0000_ff80, 0, '0);
        add_pix(12'd110, 12'd49, 32'h40ff_8000, 32'h0000_ff80, 0, '0);
        add_pix(12'd110, 12'd82, 32'h40ff_8000, 32'h0000_ff80, 0, '0); // first pixel below
        add_pix(12'd90,  12'd40, 32'h0010_2030, 32'hffee_ddcc, 0, '0); // corner, root 14
        add_pix(12'd80,  12'd60, 32'h0010_2030, 32'hffee_ddcc, 0, '0); // exactly at margin
        add_pix(12'd79,  12'd60, 32'h0010_2030, 32'h5a5a_5a5a, 1, 32'h5a5a_5a5a);
        add_pix(12'd80,  12'd30, 32'h0010_2030, 32'h6b6b_6b6b, 1, 32'h6b6b_6b6b);
        add_pix(12'd140, 12'd90, 32'hff12_3456, 32'habcd_ef01, 0, '0); // opaque-max alpha
        add_pix(12'd133, 12'd70, 32'h00ff_ffff, 32'hff00_0000, 0, '0);
        // All-ones writes: columns and rows get masked, box sits at the far corner
        add_reg(REG_BOX_LEFT,        12'hfff);
        add_reg(REG_BOX_TOP,         12'hfff);
        add_reg(REG_BOX_COLUMNS,     12'hfff);
        add_reg(REG_BOX_ROWS,        12'hfff);
        add_reg(REG_GRADIENT_MARGIN, 12'hfff);
        add_reg(REG_SPARE_FIRST,     12'h000);
        add_reg(REG_SPARE_LAST,      12'h000);
        add_pix(12'd4095, 12'd4095, 32'h7f00_ff00, 32'h0000_0000, 1, 32'h7f00_ff00);
        add_pix(12'd0,    12'd0,    32'h0000_0000, 32'hc0ff_ee00, 1, 32'hc0ff_ee00);
        add_pix(12'd0,    12'd4095, 32'h00ff_ffff, 32'h0000_0000, 0, '0);
        add_pix(12'd4094, 12'd4095, 32'h00ff_ffff, 32'h0000_0000, 0, '0);
        // One-pixel margin: the ramp jumps straight to full alpha
        add_reg(REG_GRADIENT_MARGIN, 12'd1);
        add_pix(12'd4094, 12'd4095, 32'h00ff_ffff, 32'h0000_0000, 0, '0);
        add_pix(12'd4093, 12'd4095, 32'h00ff_ffff, 32'h0012_3456, 1, 32'h0012_3456);
        // Gradient off: outside the box is background only
        add_reg(REG_GRADIENT_MARGIN, 12'd0);
        add_pix(12'd4094, 12'd4095, 32'h00ff_ffff, 32'h00ab_cdef, 1, 32'h00ab_cdef);
    endtask

    task automatic run_directed();
        int i;
        for (i = 0; i < directed_rows.size(); i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                // quiesce before touching the registers
                if (i > 0 && directed_rows[i-1].kind == ROW_PIX) begin
                    hold_sender();
                    wait_drained();
                end
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                if (i > 0 && directed_rows[i-1].kind == ROW_CFG) hold_cfg();
                send_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].colour,
                           directed_rows[i].bg, directed_rows[i].has_want,
                           directed_rows[i].want);
            end
        end
        hold_sender();
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Random phases
    // ------------------------------------------------------------------------

    task automatic setup_phase(input int ph);
        logic [COORD_W-1:0]  left, top;
        logic [MARGIN_W-1:0] margin;
        logic [COL_W-1:0]    cols;
        logic [ROW_W-1:0]    rows;
        left   = 12'($urandom_range(0, 4095));
        top    = 12'($urandom_range(0, 4095));
        cols   = 9'($urandom_range(0, 40));
        rows   = 8'($urandom_range(0, 20));
        margin = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(1, 64))
                                            : 12'($urandom_range(1, 4095));
        case (ph)
            0: begin
                left   = 12'($urandom_range(20, 400));
                top    = 12'($urandom_range(20, 400));
                margin = 12'd1;
            end
            1: begin
                // empty box in the far corner, widest margin
                left   = 12'hfff;
                top    = 12'hfff;
                cols   = '0;
                rows   = '0;
                margin = 12'hfff;
            end
            2: margin = '0;
            3: begin
                left   = '0;
                top    = '0;
                cols   = '1;
                rows   = '1;
                margin = 12'($urandom_range(1, 16));
            end
            4: cols = '0;
            default: ;
        endcase
        write_reg(REG_BOX_LEFT, left);
        write_reg(REG_BOX_TOP, top);
        // random bits above the register width must be dropped
        write_reg(REG_BOX_COLUMNS, {3'($urandom_range(0, 7)), cols});
        write_reg(REG_BOX_ROWS, {4'($urandom_range(0, 15)), rows});
        write_reg(REG_GRADIENT_MARGIN, margin);
        if ($urandom_range(0, 2) == 0)
            write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      12'($urandom_range(0, 4095)));
    endtask

    // Aim most pixels at the box and its margin, the rest anywhere
    task automatic random_pixel();
        int               left, top, right, bottom, span, lo, hi, r;
        logic [COORD_W-1:0] x, y;
        logic [PIX_W-1:0] colour;
        left   = int'(model_cfg.left);
        top    = int'(model_cfg.top);
        right  = left + CELL_WIDTH * int'(model_cfg.cols);
        bottom = top + CELL_HEIGHT * int'(model_cfg.rows);
        span   = int'(model_cfg.margin) + 3;
        r      = $urandom_range(0, 99);
        if (r < 15) begin
            x = 12'($urandom_range(0, 4095));
            y = 12'($urandom_range(0, 4095));
        end else if (r < 30 && right > left && bottom > top) begin
            x = 12'(($urandom_range(left, right - 1) > 4095) ? 4095
                                                               : $urandom_range(left, right - 1));
            y = 12'(($urandom_range(top, bottom - 1) > 4095) ? 4095
                                                               : $urandom_range(top, bottom - 1));
        end else begin
            lo = (left - span < 0) ? 0 : left - span;
            hi = (right + span > 4095) ? 4095 : right + span;
            x  = 12'($urandom_range(lo, hi));
            lo = (top - span < 0) ? 0 : top - span;
            hi = (bottom + span > 4095) ? 4095 : bottom + span;
            y  = 12'($urandom_range(lo, hi));
        end
        colour = $urandom();
        r      = $urandom_range(0, 9);
        if (r == 0) colour[31:24] = 8'h00;
        if (r == 1) colour[31:24] = 8'hff;
        send_pixel(x, y, colour, $urandom(), 0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        int ph, n;
        build_directed();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            setup_phase(ph);
            hold_cfg();
            sender_calm = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_PIXELS; n++) begin
                // hold off mid-phase until the pipe runs dry
                if (n == PHASE_PIXELS / 2 && (ph == 0 || $urandom_range(0, 2) == 0)) begin
                    hold_sender();
                    wait_drained();
                end
                random_pixel();
            end
            hold_sender();
            wait_drained();
        end

        // let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pixel_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
